>>> design/gmdfs_pkg.sv
// gmdfs_pkg: shared types and constants for the grid maze path finder
// used by gmdfs_ctrl, gmdfs_dp and grid_maze_dfs_path_finder_unit
`default_nettype none

package gmdfs_pkg;

    // width of the side register and its value after reset
    localparam int SIDE_W = 5;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd10;

    // result field widths
    localparam int ROW_IDX_W = 4;
    localparam int ROW_MARK_W = 16;

    // search directions, tried in this order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // controller states
    typedef enum logic [3:0] {
        ST_LOAD     = 4'd0,
        ST_INIT     = 4'd1,
        ST_EVAL     = 4'd2,
        ST_CHECK    = 4'd3,
        ST_ADVANCE  = 4'd4,
        ST_POP      = 4'd5,
        ST_END_RD   = 4'd6,
        ST_END_WR   = 4'd7,
        ST_OUT_RD   = 4'd8,
        ST_OUT_SHOW = 4'd9,
        ST_NOPATH   = 4'd10
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // cell transfer: write open map, step load position
        logic search_init; // clear path marks, mark start, start cell on top
        logic eval_rd;     // latch neighbor, read its open bit and mark row
        logic push;        // enter neighbor
        logic dir_inc;     // try next direction
        logic pop_rd;      // read mark row of top and stack entry below
        logic pop;         // unmark top and restore entry below
        logic end_rd;      // read mark row of end cell
        logic end_wr;      // mark end cell, flag path found
        logic out_rd;      // read mark row for the next result
        logic out_next;    // step to the next result row
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_cell;   // load position is the final cell
        logic n_is_one;    // maze is a single cell
        logic nb_oob;      // neighbor lies outside the maze
        logic nb_is_end;   // neighbor is the end cell
        logic nb_free;     // neighbor is open and not on the path
        logic dir_is_last; // all directions of the top cell tried
        logic stack_empty; // nothing below the top entry
        logic out_last;    // current result row is the final one
    } dp_stat_t;

endpackage

`default_nettype wire

>>> design/gmdfs_ram.sv
// gmdfs_ram: generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module gmdfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/gmdfs_ctrl.sv
// gmdfs_ctrl: state machine sequencing load, depth-first search and result rows
// depends on gmdfs_pkg
`default_nettype none

module gmdfs_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire gmdfs_pkg::dp_stat_t stat,
    output gmdfs_pkg::dp_cmd_t      cmd
);

    gmdfs_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gmdfs_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gmdfs_pkg::ST_LOAD: begin
                if (s_valid && stat.last_cell) begin
                    state_next = gmdfs_pkg::ST_INIT;
                end
            end
            gmdfs_pkg::ST_INIT: begin
                state_next = stat.n_is_one ? gmdfs_pkg::ST_END_RD : gmdfs_pkg::ST_EVAL;
            end
            gmdfs_pkg::ST_EVAL: begin
                if (stat.nb_oob) begin
                    state_next = gmdfs_pkg::ST_ADVANCE;
                end else if (stat.nb_is_end) begin
                    state_next = gmdfs_pkg::ST_END_RD;
                end else begin
                    state_next = gmdfs_pkg::ST_CHECK;
                end
            end
            gmdfs_pkg::ST_CHECK: begin
                state_next = stat.nb_free ? gmdfs_pkg::ST_EVAL : gmdfs_pkg::ST_ADVANCE;
            end
            gmdfs_pkg::ST_ADVANCE: begin
                if (!stat.dir_is_last) begin
                    state_next = gmdfs_pkg::ST_EVAL;
                end else if (stat.stack_empty) begin
                    state_next = gmdfs_pkg::ST_NOPATH;
                end else begin
                    state_next = gmdfs_pkg::ST_POP;
                end
            end
            gmdfs_pkg::ST_POP: begin
                state_next = gmdfs_pkg::ST_ADVANCE;
            end
            gmdfs_pkg::ST_END_RD: begin
                state_next = gmdfs_pkg::ST_END_WR;
            end
            gmdfs_pkg::ST_END_WR: begin
                state_next = gmdfs_pkg::ST_OUT_RD;
            end
            gmdfs_pkg::ST_OUT_RD: begin
                state_next = gmdfs_pkg::ST_OUT_SHOW;
            end
            gmdfs_pkg::ST_OUT_SHOW: begin
                if (m_ready) begin
                    state_next = stat.out_last ? gmdfs_pkg::ST_LOAD : gmdfs_pkg::ST_OUT_RD;
                end
            end
            gmdfs_pkg::ST_NOPATH: begin
                if (m_ready) begin
                    state_next = gmdfs_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = gmdfs_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            gmdfs_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            gmdfs_pkg::ST_INIT: begin
                cmd.search_init = 1'b1;
            end
            gmdfs_pkg::ST_EVAL: begin
                cmd.eval_rd = 1'b1;
            end
            gmdfs_pkg::ST_CHECK: begin
                cmd.push = stat.nb_free;
            end
            gmdfs_pkg::ST_ADVANCE: begin
                cmd.dir_inc = !stat.dir_is_last;
                cmd.pop_rd  = stat.dir_is_last && !stat.stack_empty;
            end
            gmdfs_pkg::ST_POP: begin
                cmd.pop = 1'b1;
            end
            gmdfs_pkg::ST_END_RD: begin
                cmd.end_rd = 1'b1;
            end
            gmdfs_pkg::ST_END_WR: begin
                cmd.end_wr = 1'b1;
            end
            gmdfs_pkg::ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
            end
            gmdfs_pkg::ST_OUT_SHOW: begin
                m_valid      = 1'b1;
                cmd.out_next = m_ready && !stat.out_last;
            end
            gmdfs_pkg::ST_NOPATH: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/gmdfs_dp.sv
// gmdfs_dp: maze storage, path mark rows, search stack and result fields
// depends on gmdfs_pkg and gmdfs_ram
`default_nettype none

module gmdfs_dp #(
    parameter int MAX_SIDE = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gmdfs_pkg::SIDE_W-1:0]          cfg_wr_data,
    input  wire logic                                  s_cell_open,
    input  wire gmdfs_pkg::dp_cmd_t                    cmd,
    output gmdfs_pkg::dp_stat_t                        stat,
    output logic                                       m_found,
    output logic [gmdfs_pkg::ROW_IDX_W-1:0]            m_row_index,
    output logic [gmdfs_pkg::ROW_MARK_W-1:0]           m_row_marks,
    output logic                                       m_last_row
);

    localparam int RCW    = $clog2(MAX_SIDE);
    localparam int OAW    = 2 * RCW;
    localparam int ODEPTH = 1 << OAW;
    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int SAW    = $clog2(CELLS);
    localparam int SW     = 2 * RCW + 2;
    localparam logic [RCW-1:0]      RC_ONE   = RCW'(1);
    localparam logic [SAW-1:0]      SA_ONE   = SAW'(1);
    localparam logic [MAX_SIDE-1:0] ROW_ONE  = MAX_SIDE'(1);
    localparam logic [RCW-1:0]      LIM_MAX  = RCW'(MAX_SIDE - 1);

    // configuration and load position
    logic [gmdfs_pkg::SIDE_W-1:0] side_reg;
    logic [RCW-1:0] ld_row_reg, ld_row_next;
    logic [RCW-1:0] ld_col_reg, ld_col_next;
    logic [RCW-1:0] lim;

    // search state
    logic [RCW-1:0]       top_row_reg, top_row_next;
    logic [RCW-1:0]       top_col_reg, top_col_next;
    gmdfs_pkg::dir_t      top_dir_reg, top_dir_next;
    logic [SAW-1:0]       cnt_reg, cnt_next;
    logic [RCW-1:0]       nb_row_reg, nb_col_reg;
    logic [RCW-1:0]       nb_row, nb_col;
    logic                 nb_oob;
    logic [MAX_SIDE-1:0]  row_vld_reg, row_vld_next;
    logic                 mark_rvld_reg;
    logic                 found_reg, found_next;
    logic [RCW-1:0]       out_row_reg, out_row_next;

    // memory ports
    logic                 open_wdata;
    logic                 open_rdata;
    logic                 mark_we, mark_re;
    logic [RCW-1:0]       mark_waddr, mark_raddr;
    logic [MAX_SIDE-1:0]  mark_wdata, mark_rdata, mark_row;
    logic [SW-1:0]        st_wdata, st_rdata;

    // effective last row/column index from the side register
    always_comb begin
        if (side_reg == '0) begin
            lim = '0;
        end else if (int'(side_reg) > MAX_SIDE) begin
            lim = LIM_MAX;
        end else begin
            lim = RCW'(side_reg - 5'd1);
        end
    end

    // side register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= gmdfs_pkg::SIDE_RESET;
        end else if (cfg_wr_en) begin
            side_reg <= cfg_wr_data;
        end
    end

    // load position, restarted by a side write
    always_comb begin
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        if (cfg_wr_en) begin
            ld_row_next = '0;
            ld_col_next = '0;
        end else if (cmd.load) begin
            if (ld_col_reg == lim) begin
                ld_col_next = '0;
                ld_row_next = (ld_row_reg == lim) ? '0 : ld_row_reg + RC_ONE;
            end else begin
                ld_col_next = ld_col_reg + RC_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end else begin
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
        end
    end

    // start and end cells are forced open
    assign open_wdata = s_cell_open
                        || (ld_row_reg == '0 && ld_col_reg == '0)
                        || stat.last_cell;

    // neighbor of the top cell in its current direction
    always_comb begin
        nb_row = top_row_reg;
        nb_col = top_col_reg;
        nb_oob = 1'b0;
        case (top_dir_reg)
            gmdfs_pkg::DIR_UP: begin
                nb_oob = (top_row_reg == '0);
                nb_row = top_row_reg - RC_ONE;
            end
            gmdfs_pkg::DIR_DOWN: begin
                nb_oob = (top_row_reg == lim);
                nb_row = top_row_reg + RC_ONE;
            end
            gmdfs_pkg::DIR_LEFT: begin
                nb_oob = (top_col_reg == '0);
                nb_col = top_col_reg - RC_ONE;
            end
            gmdfs_pkg::DIR_RIGHT: begin
                nb_oob = (top_col_reg == lim);
                nb_col = top_col_reg + RC_ONE;
            end
            default: begin
                nb_oob = 1'b1;
            end
        endcase
    end

    // mark row as read, invalid rows read as zero
    assign mark_row = mark_rvld_reg ? mark_rdata : '0;

    // mark row ram port selection
    always_comb begin
        mark_re    = 1'b0;
        mark_raddr = out_row_reg;
        if (cmd.eval_rd) begin
            mark_re    = 1'b1;
            mark_raddr = nb_row;
        end else if (cmd.pop_rd) begin
            mark_re    = 1'b1;
            mark_raddr = top_row_reg;
        end else if (cmd.end_rd) begin
            mark_re    = 1'b1;
            mark_raddr = lim;
        end else if (cmd.out_rd) begin
            mark_re    = 1'b1;
            mark_raddr = out_row_reg;
        end
    end

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = '0;
        mark_wdata = ROW_ONE;
        if (cmd.search_init) begin
            mark_we    = 1'b1;
            mark_waddr = '0;
            mark_wdata = ROW_ONE;
        end else if (cmd.push) begin
            mark_we    = 1'b1;
            mark_waddr = nb_row_reg;
            mark_wdata = mark_row | (ROW_ONE << nb_col_reg);
        end else if (cmd.pop) begin
            mark_we    = 1'b1;
            mark_waddr = top_row_reg;
            mark_wdata = mark_row & ~(ROW_ONE << top_col_reg);
        end else if (cmd.end_wr) begin
            mark_we    = 1'b1;
            mark_waddr = lim;
            mark_wdata = mark_row | (ROW_ONE << lim);
        end
    end

    // row valid bits, all but row 0 cleared at search start
    always_comb begin
        row_vld_next = row_vld_reg;
        if (cmd.search_init) begin
            row_vld_next = ROW_ONE;
        end else if (mark_we) begin
            row_vld_next = row_vld_reg | (ROW_ONE << mark_waddr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg   <= '0;
            mark_rvld_reg <= 1'b0;
        end else begin
            row_vld_reg <= row_vld_next;
            if (mark_re) begin
                mark_rvld_reg <= row_vld_reg[mark_raddr];
            end
        end
    end

    // stack top, entry count and result row
    assign st_wdata = {top_row_reg, top_col_reg, 2'(top_dir_reg)};

    always_comb begin
        top_row_next = top_row_reg;
        top_col_next = top_col_reg;
        top_dir_next = top_dir_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        out_row_next = out_row_reg;
        if (cmd.search_init) begin
            top_row_next = '0;
            top_col_next = '0;
            top_dir_next = gmdfs_pkg::DIR_UP;
            cnt_next     = '0;
            found_next   = 1'b0;
            out_row_next = '0;
        end
        if (cmd.push) begin
            top_row_next = nb_row_reg;
            top_col_next = nb_col_reg;
            top_dir_next = gmdfs_pkg::DIR_UP;
            cnt_next     = cnt_reg + SA_ONE;
        end
        if (cmd.dir_inc) begin
            top_dir_next = gmdfs_pkg::dir_t'(2'(top_dir_reg) + 2'd1);
        end
        if (cmd.pop) begin
            top_row_next = st_rdata[SW-1 -: RCW];
            top_col_next = st_rdata[RCW+1 -: RCW];
            top_dir_next = gmdfs_pkg::dir_t'(st_rdata[1:0]);
            cnt_next     = cnt_reg - SA_ONE;
        end
        if (cmd.end_wr) begin
            found_next = 1'b1;
        end
        if (cmd.out_next) begin
            out_row_next = out_row_reg + RC_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_row_reg <= '0;
            top_col_reg <= '0;
            top_dir_reg <= gmdfs_pkg::DIR_UP;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            out_row_reg <= '0;
        end else begin
            top_row_reg <= top_row_next;
            top_col_reg <= top_col_next;
            top_dir_reg <= top_dir_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            out_row_reg <= out_row_next;
        end
    end

    // neighbor latched for the check cycle
    always_ff @(posedge aclk) begin
        if (cmd.eval_rd) begin
            nb_row_reg <= nb_row;
            nb_col_reg <= nb_col;
        end
    end

    // passage bit per cell, addressed by row and column
    gmdfs_ram #(
        .WIDTH (1),
        .DEPTH (ODEPTH)
    ) u_open_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr ({ld_row_reg, ld_col_reg}),
        .wdata (open_wdata),
        .re    (cmd.eval_rd),
        .raddr ({nb_row, nb_col}),
        .rdata (open_rdata)
    );

    // path marks, one row per word
    gmdfs_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // entries below the top of the search stack
    gmdfs_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (cnt_reg),
        .wdata (st_wdata),
        .re    (cmd.pop_rd),
        .raddr (cnt_reg - SA_ONE),
        .rdata (st_rdata)
    );

    // status to the controller
    always_comb begin
        stat.last_cell   = (ld_row_reg == lim) && (ld_col_reg == lim);
        stat.n_is_one    = (lim == '0);
        stat.nb_oob      = nb_oob;
        stat.nb_is_end   = (nb_row == lim) && (nb_col == lim);
        stat.nb_free     = open_rdata && !mark_row[nb_col_reg];
        stat.dir_is_last = (top_dir_reg == gmdfs_pkg::DIR_RIGHT);
        stat.stack_empty = (cnt_reg == '0);
        stat.out_last    = (out_row_reg == lim);
    end

    // result fields, a single not-found item when no path exists
    assign m_found     = found_reg;
    assign m_row_index = found_reg ? gmdfs_pkg::ROW_IDX_W'(out_row_reg) : '0;
    assign m_row_marks = found_reg ? gmdfs_pkg::ROW_MARK_W'(mark_row) : '0;
    assign m_last_row  = !found_reg || (out_row_reg == lim);

endmodule

`default_nettype wire

>>> design/grid_maze_dfs_path_finder_unit.sv
// Grid maze path finder: loads one cell per cycle, then a depth-first search
// with an explicit stack, then one result per row or one not-found result.
// Search states, data dependent with registered ram reads: free neighbor EVAL, CHECK;
// off-grid EVAL, ADVANCE; wall or marked EVAL, CHECK, ADVANCE; backtrack ADVANCE, POP.
// Reset: side = 10, load position 0, path marks cleared at once by row valid bits;
// maze and stack rams are not cleared, so no clearing pass is needed.
`default_nettype none

module grid_maze_dfs_path_finder_unit #(
    parameter int MAX_SIDE = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gmdfs_pkg::SIDE_W-1:0]      cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_cell_open,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic [gmdfs_pkg::ROW_IDX_W-1:0]        m_row_index,
    output logic [gmdfs_pkg::ROW_MARK_W-1:0]       m_row_marks,
    output logic                                   m_last_row
);

    gmdfs_pkg::dp_cmd_t  cmd;
    gmdfs_pkg::dp_stat_t stat;

    // controller
    gmdfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    gmdfs_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_cell_open (s_cell_open),
        .cmd         (cmd),
        .stat        (stat),
        .m_found     (m_found),
        .m_row_index (m_row_index),
        .m_row_marks (m_row_marks),
        .m_last_row  (m_last_row)
    );

endmodule

`default_nettype wire

>>> tb/grid_maze_dfs_path_finder_unit_tb.sv
// grid_maze_dfs_path_finder_unit_tb: self-checking bench for the maze path finder
// depends on gmdfs_pkg and grid_maze_dfs_path_finder_unit; row results are predicted
// by a local depth-first search and every m_ transfer is checked in order
module grid_maze_dfs_path_finder_unit_tb;

    localparam int MAX_SIDE      = 16;
    localparam int CELLS         = MAX_SIDE * MAX_SIDE;
    localparam int SEARCH_BUDGET = 2000;
    localparam int NO_LIMIT      = 32'h7fff_ffff;
    localparam int STALL_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                             found;
        logic [gmdfs_pkg::ROW_IDX_W-1:0]  row_index;
        logic [gmdfs_pkg::ROW_MARK_W-1:0] row_marks;
        logic                             last_row;
    } row_result_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [gmdfs_pkg::SIDE_W-1:0]     cfg_wr_data = '0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic                             s_cell_open = 1'b0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic                             m_found;
    logic [gmdfs_pkg::ROW_IDX_W-1:0]  m_row_index;
    logic [gmdfs_pkg::ROW_MARK_W-1:0] m_row_marks;
    logic                             m_last_row;

    // shadow copy of the block state
    logic [gmdfs_pkg::SIDE_W-1:0] side_shadow = gmdfs_pkg::SIDE_RESET;
    int                load_pos    = 0;
    logic [CELLS-1:0]  open_shadow = '0;
    row_result_t       expected_rows[$];

    int error_count  = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;

    grid_maze_dfs_path_finder_unit #(.MAX_SIDE(MAX_SIDE)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_open (s_cell_open),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_row_index (m_row_index),
        .m_row_marks (m_row_marks),
        .m_last_row  (m_last_row)
    );

    always #4 aclk = ~aclk;

    // side in use: zero acts as one, anything past the maximum acts as the maximum
    function automatic int maze_span(input logic [gmdfs_pkg::SIDE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIDE) return MAX_SIDE;
        return int'(s);
    endfunction

    // depth-first search from top-left to bottom-right; marks are cleared on backtrack
    // steps counts loop passes, and the search gives up once it passes cap
    function automatic bit dfs_solve(input logic [CELLS-1:0] omap, input int n,
                                     input int cap, output logic [CELLS-1:0] marks,
                                     output int steps);
        logic [9:0] stk [CELLS];
        logic [7:0] cur_pos;
        logic [1:0] d;
        int depth, top, r, c, nr, nc, nb;
        bit back, ok;
        marks    = '0;
        steps    = 0;
        back     = 1'b0;
        marks[0] = 1'b1;
        if (n == 1) return 1'b1;
        stk[0] = '0;
        depth  = 1;
        while (depth > 0) begin
            steps++;
            if (steps > cap) return 1'b0;
            top     = depth - 1;
            cur_pos = stk[top][9:2];
            d       = stk[top][1:0];
            if (back) begin
                back = 1'b0;
                // every direction tried: unmark and pop
                if (d == gmdfs_pkg::DIR_RIGHT) begin
                    marks[cur_pos] = 1'b0;
                    depth = top;
                    back  = 1'b1;
                    continue;
                end
                d = d + 2'd1;
                stk[top] = {cur_pos, d};
            end
            r  = cur_pos / MAX_SIDE;
            c  = cur_pos % MAX_SIDE;
            nr = r;
            nc = c;
            ok = 1'b1;
            case (d)
                gmdfs_pkg::DIR_UP:    if (r == 0) ok = 1'b0; else nr = r - 1;
                gmdfs_pkg::DIR_DOWN: begin
                    nr = r + 1;
                    ok = (nr < n);
                end
                gmdfs_pkg::DIR_LEFT:  if (c == 0) ok = 1'b0; else nc = c - 1;
                default: begin
                    nc = c + 1;
                    ok = (nc < n);
                end
            endcase
            nb = nr * MAX_SIDE + nc;
            // the end cell is taken whatever its map bit
            if (ok && nr == n - 1 && nc == n - 1) begin
                marks[nb] = 1'b1;
                return 1'b1;
            end
            if (!ok || !omap[nb] || marks[nb]) begin
                back = 1'b1;
                continue;
            end
            marks[nb] = 1'b1;
            if (depth < CELLS) begin
                stk[depth] = {8'(nb), 2'b00};
                depth++;
            end else begin
                marks[nb] = 1'b0;
                back = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // one accepted cell: store it, and on the final cell queue the row results
    task automatic take_cell(input logic v);
        logic [CELLS-1:0] marks;
        row_result_t rr;
        int n, r, c, steps;
        bit last, hit;
        n    = maze_span(side_shadow);
        r    = load_pos / n;
        c    = load_pos % n;
        last = (load_pos + 1 >= n * n);
        open_shadow[r * MAX_SIDE + c] = (load_pos == 0 || last) ? 1'b1 : v;
        if (!last) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        hit = dfs_solve(open_shadow, n, NO_LIMIT, marks, steps);
        if (!hit) begin
            rr = '0;
            rr.last_row = 1'b1;
            expected_rows.push_back(rr);
        end else begin
            for (r = 0; r < n; r++) begin
                rr.found     = 1'b1;
                rr.row_index = gmdfs_pkg::ROW_IDX_W'(r);
                rr.row_marks = marks[r * MAX_SIDE +: gmdfs_pkg::ROW_MARK_W];
                rr.last_row  = (r == n - 1);
                expected_rows.push_back(rr);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        error_count++;
    endtask

    // track config writes and cell transfers, check every result transfer
    always @(posedge aclk) begin : monitor
        row_result_t want;
        if (!aresetn) begin
            side_shadow = gmdfs_pkg::SIDE_RESET;
            load_pos    = 0;
        end else begin
            if (cfg_wr_en) begin
                side_shadow = cfg_wr_data;
                load_pos    = 0;
            end
            if (s_valid && s_ready) take_cell(s_cell_open);
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("result with none pending, row", 32'd0,
                                    32'(m_row_index));
                end else begin
                    want = expected_rows.pop_front();
                    if (m_found !== want.found)
                        report_mismatch("found", 32'(want.found), 32'(m_found));
                    if (m_row_index !== want.row_index)
                        report_mismatch("row_index", 32'(want.row_index),
                                        32'(m_row_index));
                    if (m_row_marks !== want.row_marks)
                        report_mismatch("row_marks", 32'(want.row_marks),
                                        32'(m_row_marks));
                    if (m_last_row !== want.last_row)
                        report_mismatch("last_row", 32'(want.last_row),
                                        32'(m_last_row));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side ready with random stall bursts
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    end

    // one cell transfer, with an optional gap before it
    task automatic send_cell(input logic v);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cell_open <= v;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // hold off the sender until every queued row has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_side(input logic [gmdfs_pkg::SIDE_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_maze(input int n, input logic [CELLS-1:0] cells);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_cell(cells[r * MAX_SIDE + c]);
    endtask

    // random maze whose search stays within budget; all walls as a last resort
    task automatic make_maze(input int n, output logic [CELLS-1:0] cells);
        logic [CELLS-1:0] probe, marks;
        int steps, pct, r, c;
        for (int tries = 0; tries < 8; tries++) begin
            pct   = 35 + 15 * $urandom_range(0, 4);
            cells = '0;
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                    cells[r * MAX_SIDE + c] = ($urandom_range(0, 99) < pct);
            // carve a down/right walk so that many mazes have a way through
            if ($urandom_range(0, 1)) begin
                r = 0;
                c = 0;
                while (r < n - 1 || c < n - 1) begin
                    cells[r * MAX_SIDE + c] = 1'b1;
                    if (c == n - 1 || (r < n - 1 && $urandom_range(0, 1))) r++;
                    else c++;
                end
            end
            probe = cells;
            probe[0] = 1'b1;
            probe[(n - 1) * MAX_SIDE + n - 1] = 1'b1;
            void'(dfs_solve(probe, n, SEARCH_BUDGET, marks, steps));
            if (steps <= SEARCH_BUDGET) return;
        end
        cells = '0;
    endtask

    // maze at the side left by reset, no register write
    task automatic test_reset_side();
        logic [CELLS-1:0] cells;
        make_maze(10, cells);
        send_maze(10, cells);
    endtask

    // side zero and side one: single cell, start is the end
    task automatic test_single_cell();
        write_side(5'd0);
        send_cell(1'b0);
        write_side(5'd1);
        send_cell(1'b1);
    endtask

    // 2x2: walls everywhere (start and end forced open), then both middles open
    task automatic test_two_by_two();
        write_side(5'd2);
        repeat (4) send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    // 3x3 with the middle row walled: no path
    task automatic test_blocked_middle();
        write_side(5'd3);
        repeat (3) send_cell(1'b1);
        repeat (3) send_cell(1'b0);
        repeat (3) send_cell(1'b1);
    endtask

    // side rewritten part way through a load restarts it
    task automatic test_reload_mid_load();
        write_side(5'd4);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
        write_side(5'd2);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
    endtask

    // largest register value, acting as the full 16x16 maze
    task automatic test_largest_maze();
        logic [CELLS-1:0] cells;
        write_side(5'd31);
        make_maze(MAX_SIDE, cells);
        send_maze(MAX_SIDE, cells);
    endtask

    // random small mazes, some loads cut short by a side rewrite
    task automatic test_random_mazes(input int cell_goal, input bit with_idling);
        logic [CELLS-1:0] cells;
        logic [gmdfs_pkg::SIDE_W-1:0] sv;
        int sent, n, k, cut;
        sent = 0;
        while (sent < cell_goal) begin
            idle_on = with_idling && ($urandom_range(0, 3) != 0);
            k  = $urandom_range(0, 19);
            sv = (k == 0) ? 5'd0 : (k == 1) ? 5'd1
                 : gmdfs_pkg::SIDE_W'($urandom_range(2, 8));
            write_side(sv);
            n = maze_span(sv);
            make_maze(n, cells);
            if (n > 1 && $urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, n * n - 1);
                for (int i = 0; i < cut; i++) send_cell(1'($urandom_range(0, 1)));
                sent += cut;
                write_side(sv);
            end
            send_maze(n, cells);
            sent += n * n;
        end
    endtask

    initial begin : run
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_side();
        test_single_cell();
        test_two_by_two();
        test_blocked_middle();
        test_reload_mid_load();
        test_largest_maze();
        test_random_mazes(60, 1'b1);
        idle_on = 1'b0;
        test_random_mazes(30, 1'b0);
        drain_results();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
